// File: hw/rtl/assert_macros.svh
// Assertion helpers; they expect clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define LCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define LCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types and constants of the LIFO stack with capacity policy.
// ----------------------------------------------------------------------------
package lcp_pkg;

	localparam int STORE_DEPTH  = 1024;
	localparam int ELEMENT_BITS = 32;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int FIELD_W      = 11;          // size, capacity and min capacity
	localparam int CAP2_W       = FIELD_W + 1; // room for 2c+1
	localparam int VAL_W        = 32;          // push_value / pop_value fields

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RESIZED = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef struct packed {
		logic             command;
		logic [VAL_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   pop_value;
		logic [FIELD_W-1:0] size_after;
		logic [FIELD_W-1:0] capacity_after;
	} out_item_t;

	// memory request from the controller
	typedef struct packed {
		logic                    we;
		logic [ADDR_W-1:0]       waddr;
		logic [ELEMENT_BITS-1:0] wdata;
		logic                    re;
		logic [ADDR_W-1:0]       raddr;
	} ram_req_t;

	// per-item outcome handed to the result pipeline
	typedef struct packed {
		status_t            status;
		logic               pop_ok;
		logic [FIELD_W-1:0] size_after;
		logic [FIELD_W-1:0] capacity_after;
	} ctl_t;

endpackage

// File: hw/rtl/lcp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lcp_ram (
	input  logic                            clk,
	input  lcp_pkg::ram_req_t               req,
	output logic [lcp_pkg::ELEMENT_BITS-1:0] rdata
);

	logic [lcp_pkg::ELEMENT_BITS-1:0] mem [lcp_pkg::STORE_DEPTH];
	logic [lcp_pkg::ELEMENT_BITS-1:0] rdata_q;

	// read data only changes on a read, so it holds while the result waits
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/lcp_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lcp_ctrl
// Count, capacity and min capacity registers; decides each push or pop.
// ----------------------------------------------------------------------------
module lcp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lcp_pkg::FIELD_W-1:0] cfg_wdata,
	input  logic                        accept,
	input  lcp_pkg::in_item_t           item,
	output lcp_pkg::ram_req_t           req,
	output lcp_pkg::ctl_t               res
);

	logic [lcp_pkg::FIELD_W-1:0] count_q;
	logic [lcp_pkg::FIELD_W-1:0] cap_q;
	logic [lcp_pkg::FIELD_W-1:0] min_q;
	logic [lcp_pkg::FIELD_W-1:0] nxt_count;
	logic [lcp_pkg::FIELD_W-1:0] nxt_cap;
	logic [lcp_pkg::FIELD_W-1:0] cnt_dec;
	logic [lcp_pkg::FIELD_W-1:0] cap_m3;
	logic [lcp_pkg::FIELD_W-1:0] cap_m1;
	logic [lcp_pkg::CAP2_W-1:0]  cap2;
	logic                        grow;
	logic                        grow_fail;
	logic                        full;
	logic                        push_ok;
	logic                        shrink;
	logic                        is_push;
	logic                        is_empty;

	always_comb begin
		is_push   = (item.command == lcp_pkg::CMD_PUSH);
		is_empty  = (count_q == '0);
		grow      = (count_q >= cap_q);
		cap2      = {cap_q, 1'b1};
		grow_fail = grow && (cap2 > lcp_pkg::CAP2_W'(lcp_pkg::STORE_DEPTH));
		full      = (count_q >= lcp_pkg::FIELD_W'(lcp_pkg::STORE_DEPTH));
		push_ok   = !grow_fail && !full;
		cnt_dec   = count_q - lcp_pkg::FIELD_W'(1);
		cap_m3    = cap_q - lcp_pkg::FIELD_W'(3);
		cap_m1    = cap_q - lcp_pkg::FIELD_W'(1);
		shrink    = (cap_q >= lcp_pkg::FIELD_W'(3)) && (cnt_dec == (cap_m3 >> 2))
			&& (cnt_dec >= min_q);

		req       = '0;
		res       = '0;
		nxt_count = count_q;
		nxt_cap   = cap_q;
		res.status = lcp_pkg::ST_OK;

		if (is_push) begin
			if (push_ok) begin
				req.we    = accept;
				req.waddr = count_q[lcp_pkg::ADDR_W-1:0];
				req.wdata = lcp_pkg::ELEMENT_BITS'(item.push_value);
				nxt_count = count_q + lcp_pkg::FIELD_W'(1);
				if (grow) begin
					nxt_cap    = cap2[lcp_pkg::FIELD_W-1:0];
					res.status = lcp_pkg::ST_RESIZED;
				end
			end else begin
				res.status = lcp_pkg::ST_DROPPED;
			end
		end else begin
			if (is_empty) begin
				res.status = lcp_pkg::ST_EMPTY;
			end else begin
				req.re     = accept;
				req.raddr  = cnt_dec[lcp_pkg::ADDR_W-1:0];
				res.pop_ok = 1'b1;
				nxt_count  = cnt_dec;
				if (shrink) begin
					nxt_cap    = cap_m1 >> 1;
					res.status = lcp_pkg::ST_RESIZED;
				end
			end
		end

		res.size_after     = nxt_count;
		res.capacity_after = nxt_cap;
	end

	// a register write empties the stack and reloads the capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= '0;
			min_q   <= '0;
		end else if (cfg_we) begin
			min_q   <= cfg_wdata;
			count_q <= '0;
			cap_q   <= cfg_wdata;
		end else if (accept) begin
			count_q <= nxt_count;
			cap_q   <= nxt_cap;
		end
	end

	`LCP_ASSERT(a_count_bound, count_q <= lcp_pkg::FIELD_W'(lcp_pkg::STORE_DEPTH),
		"element count beyond store depth")
	`LCP_ASSERT_NEXT(a_push_inc, accept && !cfg_we && is_push && push_ok,
		count_q == $past(count_q) + lcp_pkg::FIELD_W'(1), "push did not bump count")
	`LCP_ASSERT_NEXT(a_empty_pop_hold, accept && !cfg_we && !is_push && is_empty,
		$stable(count_q) && $stable(cap_q), "empty pop changed state")

endmodule

// File: hw/rtl/lifo_stack_with_capacity_policy.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lifo_stack_with_capacity_policy
// LIFO stack of 1024 x 32-bit elements with a logical capacity that grows
// to 2c+1 on a push at capacity and shrinks to (c-1)/2 on a sparse pop.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per accepted handshake (in_valid high, in_stall low);
//            command 0 pushes push_value, command 1 pops the top element.
//   out_*  : exactly one result item per input item, in order, taken when
//            out_valid is high and out_stall is low.
//   cfg_we : writes min_capacity from cfg_wdata; empties the stack and sets
//            the capacity. Write only while no item is in flight.
// Timing: an item is decided in its accept cycle (count/capacity update and
//   the store write or read issue), the registered store read data is there
//   right after the accept edge, and the result is loaded into the output
//   register when the middle stage advances, and is taken from there.
//   One item per cycle is sustained while out_stall is low; the store's one
//   write and one read port handle the one write or read that each item needs.
// Reset: count, capacity and min capacity clear to zero; the store is not
//   cleared since only entries written by a push are ever read.
// Stall: a stalled output holds; one more item is decided and parked in the
//   middle stage, after which in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module lifo_stack_with_capacity_policy (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lcp_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lcp_pkg::out_item_t          out_item,
	input  logic                        cfg_we,
	input  logic [lcp_pkg::FIELD_W-1:0] cfg_wdata
);

	lcp_pkg::ram_req_t                ram_req;
	lcp_pkg::ctl_t                    ctl;
	lcp_pkg::ctl_t                    ctl_s1;
	lcp_pkg::out_item_t               out_item_q;
	logic [lcp_pkg::ELEMENT_BITS-1:0] rdata;
	logic                             s1_valid_q;
	logic                             out_valid_q;
	logic                             accept;
	logic                             advance;

	// output register frees when empty or taken this cycle
	assign advance  = !out_valid_q || !out_stall;
	// middle stage frees when empty or moving into the output register
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;

	lcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.item      (in_item),
		.req       (ram_req),
		.res       (ctl)
	);

	lcp_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_valid_q && advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: stage 1 holds the decision, store data arrives alongside it
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
		end
		if (s1_valid_q && advance) begin
			out_item_q.status         <= ctl_s1.status;
			out_item_q.pop_value      <= ctl_s1.pop_ok ? lcp_pkg::VAL_W'(rdata) : '0;
			out_item_q.size_after     <= ctl_s1.size_after;
			out_item_q.capacity_after <= ctl_s1.capacity_after;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`LCP_ASSERT(a_stall_cause, !in_stall || (s1_valid_q && out_valid_q && out_stall),
		"input stalled with room in the pipeline")
	`LCP_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance,
		s1_valid_q && $stable(ctl_s1), "parked item lost or changed")
	`LCP_ASSERT_NEXT(a_s1_move, s1_valid_q && advance, out_valid_q,
		"item left stage 1 without reaching the output")

endmodule
